// ===== rtl/ale_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and codes for the array list engine.
// No dependencies; used by array_list_engine and the testbench.
package ale_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of the stream items
  localparam int OP_W  = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;
  localparam int FND_W = 4;
  localparam int REM_W = 5;
  localparam int ENT_W = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_DELETE = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FIND   = 3'd5,
    OP_READ   = 3'd6
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

// ===== rtl/ale_ram.sv =====
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/array_list_engine.sv =====
`timescale 1ns / 1ps
// Top level of the array list engine: command sequencer and entry count.
// Depends on ale_pkg and ale_ram.
//
// Usage:
//   Commands arrive on the in_ stream, one transfer per command; each command
//   yields exactly one result transfer on the out_ stream, in order.
//   The list words sit in a small RAM with one write and one registered read
//   port; a single sequencer walks it one entry per cycle for every command
//   that shifts, searches or reads.
//   Append, refused commands, unused opcodes and empty find or remove go
//   straight to the result state. Pop and read walk one entry, delete walks
//   from its position to the last entry, remove all and find walk every
//   entry, and each walk then drains; insert walks down over the entries it
//   moves, drains and then writes the new word (at once when none move).
//   The walk reads the RAM one entry a cycle. One command is in flight at a
//   time: in_tready is high only while the sequencer is idle.
//   A finished result is held in the output register; if the receiver stalls
//   (out_tready low) the sequencer holds in its final state until the
//   register frees, and no new command is taken meanwhile.
//   Reset clears the entry count and all handshake state; the RAM contents
//   are not cleared, since only positions below the count are ever read.
module array_list_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  // Command stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ale_pkg::IN_TDATA_W-1:0]   in_tdata,  // opcode[2:0] position[7:3] value[39:8]
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ale_pkg::OUT_TDATA_W-1:0]  out_tdata  // status[2:0] data[34:3] found_at[38:35]
                                                      // removed[43:39] entry_count[48:44]
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_INS,
    S_FIN
  } state_t;

  // Unpack the command
  logic [ale_pkg::OP_W-1:0]  in_op;
  logic [ale_pkg::POS_W-1:0] in_pos;
  logic [ale_pkg::VAL_W-1:0] in_val;

  assign in_op  = in_tdata[ale_pkg::OP_W-1:0];
  assign in_pos = in_tdata[ale_pkg::OP_W +: ale_pkg::POS_W];
  assign in_val = in_tdata[ale_pkg::OP_W + ale_pkg::POS_W +: ale_pkg::VAL_W];

  state_t                      state_r, state_nxt;
  logic [ale_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [ale_pkg::IDX_W-1:0]   pos_r, pos_nxt;
  logic [ale_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic [ale_pkg::CNT_W-1:0]   fill_r, fill_nxt;
  logic [ale_pkg::IDX_W-1:0]   ra_r, ra_nxt;     // walk read address
  logic [ale_pkg::IDX_W-1:0]   end_r, end_nxt;   // last address of the walk
  logic                        pv_r, pv_nxt;     // read data pending
  logic [ale_pkg::IDX_W-1:0]   pa_r, pa_nxt;     // address of the pending data
  logic [ale_pkg::CNT_W-1:0]   w_r, w_nxt;       // kept count for remove all
  logic                        hit_r, hit_nxt;
  logic [ale_pkg::IDX_W-1:0]   fidx_r, fidx_nxt;
  logic [ale_pkg::VAL_W-1:0]   data_r, data_nxt;
  logic [ale_pkg::ST_W-1:0]    st_r, st_nxt;
  logic [ale_pkg::CNT_W-1:0]   rem_r, rem_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [ale_pkg::ST_W-1:0]    out_st_r, out_st_nxt;
  logic [ale_pkg::VAL_W-1:0]   out_data_r, out_data_nxt;
  logic [ale_pkg::FND_W-1:0]   out_fnd_r, out_fnd_nxt;
  logic [ale_pkg::REM_W-1:0]   out_rem_r, out_rem_nxt;
  logic [ale_pkg::ENT_W-1:0]   out_cnt_r, out_cnt_nxt;

  // RAM port signals
  logic                        ram_we;
  logic [ale_pkg::IDX_W-1:0]   ram_waddr;
  logic [ale_pkg::VAL_W-1:0]   ram_wdata;
  logic [ale_pkg::VAL_W-1:0]   ram_rdata;

  logic in_acc;
  logic is_full;
  logic list_empty;
  logic pos_gt_fill;
  logic pos_ge_fill;
  logic [ale_pkg::IDX_W-1:0] fill_m1;

  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign is_full     = (fill_r == ale_pkg::CNT_W'(ale_pkg::DEPTH));
  assign list_empty  = (fill_r == '0);
  assign pos_gt_fill = (32'(in_pos) > 32'(fill_r));
  assign pos_ge_fill = (32'(in_pos) >= 32'(fill_r));
  assign fill_m1     = ale_pkg::IDX_W'(fill_r - ale_pkg::CNT_W'(1));

  ale_ram #(
    .WIDTH (ale_pkg::VAL_W),
    .DEPTH (ale_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    fill_nxt      = fill_r;
    ra_nxt        = ra_r;
    end_nxt       = end_r;
    pv_nxt        = 1'b0;
    pa_nxt        = pa_r;
    w_nxt         = w_r;
    hit_nxt       = hit_r;
    fidx_nxt      = fidx_r;
    data_nxt      = data_r;
    st_nxt        = st_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_st_nxt    = out_st_r;
    out_data_nxt  = out_data_r;
    out_fnd_nxt   = out_fnd_r;
    out_rem_nxt   = out_rem_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = val_r;

    // Consume the word whose read was issued in the previous cycle
    if (pv_r) begin
      case (op_r)
        ale_pkg::OP_INSERT: begin
          ram_we    = 1'b1;
          ram_waddr = pa_r + ale_pkg::IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        ale_pkg::OP_DELETE: begin
          if (pa_r == pos_r) begin
            data_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pa_r - ale_pkg::IDX_W'(1);
            ram_wdata = ram_rdata;
          end
        end
        ale_pkg::OP_REMOVE: begin
          if (ram_rdata != val_r) begin
            ram_we    = 1'b1;
            ram_waddr = ale_pkg::IDX_W'(w_r);
            ram_wdata = ram_rdata;
            w_nxt     = w_r + ale_pkg::CNT_W'(1);
          end
        end
        ale_pkg::OP_FIND: begin
          if (ram_rdata == val_r && !hit_r) begin
            hit_nxt  = 1'b1;
            fidx_nxt = pa_r;
          end
        end
        default: begin
          data_nxt = ram_rdata;
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_op;
          pos_nxt  = ale_pkg::IDX_W'(in_pos);
          val_nxt  = in_val;
          w_nxt    = '0;
          hit_nxt  = 1'b0;
          fidx_nxt = '0;
          data_nxt = '0;
          rem_nxt  = '0;
          st_nxt   = ale_pkg::ST_OK;
          ra_nxt   = '0;
          end_nxt  = fill_m1;
          state_nxt = S_FIN;
          case (in_op)
            ale_pkg::OP_APPEND: begin
              if (is_full) begin
                st_nxt = ale_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ale_pkg::IDX_W'(fill_r);
                ram_wdata = in_val;
                fill_nxt  = fill_r + ale_pkg::CNT_W'(1);
              end
            end
            ale_pkg::OP_INSERT: begin
              if (is_full) begin
                st_nxt = ale_pkg::ST_FULL;
              end else if (pos_gt_fill) begin
                st_nxt = ale_pkg::ST_RANGE;
              end else if (pos_ge_fill) begin
                state_nxt = S_INS;
              end else begin
                // Walk down from the top, moving each word up one place
                ra_nxt    = fill_m1;
                end_nxt   = ale_pkg::IDX_W'(in_pos);
                state_nxt = S_WALK;
              end
            end
            ale_pkg::OP_POP: begin
              if (list_empty) begin
                st_nxt = ale_pkg::ST_EMPTY;
              end else begin
                ra_nxt    = fill_m1;
                fill_nxt  = fill_r - ale_pkg::CNT_W'(1);
                state_nxt = S_WALK;
              end
            end
            ale_pkg::OP_DELETE: begin
              if (list_empty) begin
                st_nxt = ale_pkg::ST_EMPTY;
              end else if (pos_ge_fill) begin
                st_nxt = ale_pkg::ST_RANGE;
              end else begin
                ra_nxt    = ale_pkg::IDX_W'(in_pos);
                fill_nxt  = fill_r - ale_pkg::CNT_W'(1);
                state_nxt = S_WALK;
              end
            end
            ale_pkg::OP_REMOVE, ale_pkg::OP_FIND: begin
              if (list_empty) begin
                st_nxt = ale_pkg::ST_NOTFOUND;
              end else begin
                state_nxt = S_WALK;
              end
            end
            ale_pkg::OP_READ: begin
              if (list_empty) begin
                st_nxt = ale_pkg::ST_EMPTY;
              end else if (pos_ge_fill) begin
                st_nxt = ale_pkg::ST_RANGE;
              end else begin
                ra_nxt    = ale_pkg::IDX_W'(in_pos);
                end_nxt   = ale_pkg::IDX_W'(in_pos);
                state_nxt = S_WALK;
              end
            end
            default: begin
              st_nxt = ale_pkg::ST_OK;
            end
          endcase
        end
      end

      S_WALK: begin
        // Issue one read a cycle; the word is consumed next cycle
        pv_nxt = 1'b1;
        pa_nxt = ra_r;
        if (ra_r == end_r) begin
          state_nxt = S_DRAIN;
        end else if (op_r == ale_pkg::OP_INSERT) begin
          ra_nxt = ra_r - ale_pkg::IDX_W'(1);
        end else begin
          ra_nxt = ra_r + ale_pkg::IDX_W'(1);
        end
      end

      S_DRAIN: begin
        state_nxt = S_FIN;
        case (op_r)
          ale_pkg::OP_INSERT: begin
            state_nxt = S_INS;
          end
          ale_pkg::OP_REMOVE: begin
            rem_nxt  = fill_r - w_nxt;
            fill_nxt = w_nxt;
            st_nxt   = (fill_r == w_nxt) ? ale_pkg::ST_NOTFOUND : ale_pkg::ST_OK;
          end
          ale_pkg::OP_FIND: begin
            st_nxt = hit_nxt ? ale_pkg::ST_OK : ale_pkg::ST_NOTFOUND;
          end
          default: begin
            st_nxt = ale_pkg::ST_OK;
          end
        endcase
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        fill_nxt  = fill_r + ale_pkg::CNT_W'(1);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hold here while the previous result is still waiting
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          out_data_nxt  = data_r;
          out_fnd_nxt   = ale_pkg::FND_W'(fidx_r);
          out_rem_nxt   = ale_pkg::REM_W'(rem_r);
          out_cnt_nxt   = ale_pkg::ENT_W'(fill_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    ra_r       <= ra_nxt;
    end_r      <= end_nxt;
    pa_r       <= pa_nxt;
    w_r        <= w_nxt;
    hit_r      <= hit_nxt;
    fidx_r     <= fidx_nxt;
    data_r     <= data_nxt;
    st_r       <= st_nxt;
    rem_r      <= rem_nxt;
    out_st_r   <= out_st_nxt;
    out_data_r <= out_data_nxt;
    out_fnd_r  <= out_fnd_nxt;
    out_rem_r  <= out_rem_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (ale_pkg::OUT_TDATA_W - ale_pkg::ST_W - ale_pkg::VAL_W - ale_pkg::FND_W
     - ale_pkg::REM_W - ale_pkg::ENT_W)'(0),
    out_cnt_r, out_rem_r, out_fnd_r, out_data_r, out_st_r
  };

  // The entry count never passes the capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= ale_pkg::CNT_W'(ale_pkg::DEPTH))
    else $error("entry count above capacity");

  // A taken command closes the input until its result is issued
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input open while a command is in progress");

  // Read data is pending only while walking or draining the walk
  assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_WALK || state_r == S_DRAIN))
    else $error("pending read data outside a walk");

  // From idle the RAM is written only by an accepted append
  assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_IDLE) |-> (in_acc && in_op == ale_pkg::OP_APPEND))
    else $error("stray RAM write while idle");

  // A result is loaded only into a free output register
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=> $stable(out_tdata))
    else $error("result overwritten while stalled");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for array_list_engine: directed table, then random commands.
// Depends on ale_pkg and the array_list_engine RTL; keeps its own shadow copy of the list.
module testbench;

  localparam logic [ale_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int CLK_HALF_NS     = 2;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_ITEMS    = 700;
  localparam int PHASE_ITEMS     = RANDOM_ITEMS / 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 2 * ale_pkg::DEPTH + 8;
  localparam int WATCHDOG_NS     = 2_000_000;

  // One command transfer, laid out as in_tdata: opcode in the lowest bits
  typedef struct packed {
    logic signed [ale_pkg::VAL_W-1:0] value;
    logic [ale_pkg::POS_W-1:0]        position;
    logic [ale_pkg::OP_W-1:0]         opcode;
  } list_command_t;

  // One result transfer, laid out as out_tdata, with the zero fill on top
  typedef struct packed {
    logic [ale_pkg::OUT_TDATA_W-50:0] pad;
    logic [ale_pkg::ENT_W-1:0]        entry_count;
    logic [ale_pkg::REM_W-1:0]        removed;
    logic [ale_pkg::FND_W-1:0]        found_at;
    logic signed [ale_pkg::VAL_W-1:0] data;
    ale_pkg::status_t                 status;
  } list_result_t;

  // A row of the directed table: a command, how often to send it, and
  // optionally the result written out by hand
  typedef struct {
    list_command_t cmd;
    int            repeats;
    bit            typed;
    list_result_t  result;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ale_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [ale_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Shadow of the list held by the block
  logic [ale_pkg::VAL_W-1:0] shadow_words [ale_pkg::DEPTH];
  int                        shadow_fill;

  list_result_t awaited_results [$];
  plan_row_t    directed_plan [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  bit hold_off_request   = 1'b0;
  bit hold_off_done      = 1'b0;

  int mismatch_count = 0;
  int commands_sent  = 0;
  int results_seen   = 0;
  int peak_fill      = 0;
  int status_tally [5];

  array_list_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Work out the result of one command on the shadow list and update it
  function automatic list_result_t run_list_command(input list_command_t cmd);
    list_result_t r;
    int           kept;
    int           hit;
    r = '0;
    r.status = ale_pkg::ST_OK;
    case (cmd.opcode)
      ale_pkg::OP_APPEND: begin
        if (shadow_fill >= ale_pkg::DEPTH) begin
          r.status = ale_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_fill] = cmd.value;
          shadow_fill++;
        end
      end
      ale_pkg::OP_INSERT: begin
        if (shadow_fill >= ale_pkg::DEPTH) begin
          r.status = ale_pkg::ST_FULL;
        end else if (int'(cmd.position) > shadow_fill) begin
          r.status = ale_pkg::ST_RANGE;
        end else begin
          // open a gap at the target by moving the tail up one place
          for (int i = shadow_fill; i > int'(cmd.position); i--)
            shadow_words[i] = shadow_words[i-1];
          shadow_words[cmd.position] = cmd.value;
          shadow_fill++;
        end
      end
      ale_pkg::OP_POP: begin
        if (shadow_fill == 0) begin
          r.status = ale_pkg::ST_EMPTY;
        end else begin
          shadow_fill--;
          r.data = shadow_words[shadow_fill];
        end
      end
      ale_pkg::OP_DELETE: begin
        if (shadow_fill == 0) begin
          r.status = ale_pkg::ST_EMPTY;
        end else if (int'(cmd.position) >= shadow_fill) begin
          r.status = ale_pkg::ST_RANGE;
        end else begin
          r.data = shadow_words[cmd.position];
          for (int i = cmd.position; i + 1 < shadow_fill; i++)
            shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
        end
      end
      ale_pkg::OP_REMOVE: begin
        // compact the survivors towards the front
        kept = 0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_words[i] != cmd.value) begin
            shadow_words[kept] = shadow_words[i];
            kept++;
          end
        end
        r.removed = ale_pkg::REM_W'(shadow_fill - kept);
        r.status = (shadow_fill != kept) ? ale_pkg::ST_OK : ale_pkg::ST_NOTFOUND;
        shadow_fill = kept;
      end
      ale_pkg::OP_FIND: begin
        hit = -1;
        for (int i = 0; i < shadow_fill && hit < 0; i++)
          if (shadow_words[i] == cmd.value) hit = i;
        if (hit >= 0) r.found_at = ale_pkg::FND_W'(hit);
        else r.status = ale_pkg::ST_NOTFOUND;
      end
      ale_pkg::OP_READ: begin
        if (shadow_fill == 0) r.status = ale_pkg::ST_EMPTY;
        else if (int'(cmd.position) >= shadow_fill) r.status = ale_pkg::ST_RANGE;
        else r.data = shadow_words[cmd.position];
      end
      default: begin
        // unused opcode: plain ok, list untouched
      end
    endcase
    r.entry_count = ale_pkg::ENT_W'(shadow_fill);
    return r;
  endfunction

  function automatic plan_row_t plan_row(input logic [ale_pkg::OP_W-1:0] op, input int pos,
                                         input logic [ale_pkg::VAL_W-1:0] val, input int reps,
                                         input bit typed, input ale_pkg::status_t st,
                                         input logic [ale_pkg::VAL_W-1:0] data, input int fnd,
                                         input int rem, input int cnt);
    plan_row_t row;
    row.cmd      = '{value: val, position: ale_pkg::POS_W'(pos), opcode: op};
    row.repeats  = reps;
    row.typed    = typed;
    row.result   = '0;
    row.result.status      = st;
    row.result.data        = data;
    row.result.found_at    = ale_pkg::FND_W'(fnd);
    row.result.removed     = ale_pkg::REM_W'(rem);
    row.result.entry_count = ale_pkg::ENT_W'(cnt);
    return row;
  endfunction

  // Random command, steered by the shadow fill so the list keeps moving
  // between empty and full; half the keys come from a small pool so that
  // find and remove all hit often
  function automatic list_command_t random_command();
    list_command_t c;
    int            pick;
    int            grow_pct;
    case ($urandom_range(0, 9))
      0: c.value = 32'sd0;
      1: c.value = -32'sd1;
      2: c.value = 32'sh8000_0000;
      3: c.value = 32'sh7fff_ffff;
      4: c.value = 32'sd1 + $urandom_range(0, 2);
      default: c.value = $urandom();
    endcase
    if ($urandom_range(0, 99) < 80) begin
      c.position = ale_pkg::POS_W'($urandom_range(0, shadow_fill));
    end else begin
      c.position = ale_pkg::POS_W'($urandom_range(0, ale_pkg::DEPTH));
    end
    grow_pct = 45 - 2 * shadow_fill;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      c.opcode = OP_UNUSED;
    end else if (pick < 2 + grow_pct) begin
      c.opcode = $urandom_range(0, 1) ? ale_pkg::OP_APPEND : ale_pkg::OP_INSERT;
    end else begin
      case ($urandom_range(0, 4))
        0: c.opcode = ale_pkg::OP_POP;
        1: c.opcode = ale_pkg::OP_DELETE;
        2: c.opcode = ale_pkg::OP_REMOVE;
        3: c.opcode = ale_pkg::OP_FIND;
        default: c.opcode = ale_pkg::OP_READ;
      endcase
    end
    return c;
  endfunction

  // Offer one command until it transfers, then queue what it should produce.
  // Called at a rising edge; returns at the edge of the transfer.
  task automatic offer_command(input list_command_t cmd, input bit typed,
                               input list_result_t typed_result);
    list_result_t predicted;
    if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = run_list_command(cmd);
    awaited_results.push_back(typed ? typed_result : predicted);
    commands_sent++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
  endtask

  // Command side: reset, directed table, four phases of random commands with varied idling and stalls
  initial begin
    directed_plan.push_back(plan_row(ale_pkg::OP_POP,    0,  0, 1, 1,
                                     ale_pkg::ST_EMPTY,    0, 0, 0, 0));
    directed_plan.push_back(plan_row(ale_pkg::OP_READ,   16, 0, 1, 1,
                                     ale_pkg::ST_EMPTY,    0, 0, 0, 0));
    directed_plan.push_back(plan_row(ale_pkg::OP_DELETE, 0,  0, 1, 1,
                                     ale_pkg::ST_EMPTY,    0, 0, 0, 0));
    directed_plan.push_back(plan_row(ale_pkg::OP_FIND,   0,  0, 1, 1,
                                     ale_pkg::ST_NOTFOUND, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(ale_pkg::OP_REMOVE, 0, -1, 1, 1,
                                     ale_pkg::ST_NOTFOUND, 0, 0, 0, 0));
    directed_plan.push_back(plan_row(ale_pkg::OP_INSERT, 1,  5, 1, 1,
                                     ale_pkg::ST_RANGE,    0, 0, 0, 0));
    directed_plan.push_back(plan_row(OP_UNUSED, 16, -1, 1, 1,
                                     ale_pkg::ST_OK,       0, 0, 0, 0));
    directed_plan.push_back(plan_row(ale_pkg::OP_APPEND, 0, 32'h7fff_ffff, 1, 1,
                                     ale_pkg::ST_OK, 0, 0, 0, 1));
    // insert at zero acts as a prepend
    directed_plan.push_back(plan_row(ale_pkg::OP_INSERT, 0, 32'h8000_0000, 1, 1,
                                     ale_pkg::ST_OK, 0, 0, 0, 2));
    // insert at the count acts as an append
    directed_plan.push_back(plan_row(ale_pkg::OP_INSERT, 2, -1, 1, 1,
                                     ale_pkg::ST_OK,       0, 0, 0, 3));
    directed_plan.push_back(plan_row(ale_pkg::OP_READ,   2,  0, 1, 1,
                                     ale_pkg::ST_OK,      -1, 0, 0, 3));
    directed_plan.push_back(plan_row(ale_pkg::OP_READ,   3,  0, 1, 1,
                                     ale_pkg::ST_RANGE,    0, 0, 0, 3));
    directed_plan.push_back(plan_row(ale_pkg::OP_FIND,   0, 32'h7fff_ffff, 1, 1,
                                     ale_pkg::ST_OK, 0, 1, 0, 3));
    directed_plan.push_back(plan_row(ale_pkg::OP_DELETE, 0,  0, 1, 1,
                                     ale_pkg::ST_OK, 32'h8000_0000, 0, 0, 2));
    directed_plan.push_back(plan_row(ale_pkg::OP_DELETE, 2,  0, 1, 1,
                                     ale_pkg::ST_RANGE,    0, 0, 0, 2));
    directed_plan.push_back(plan_row(ale_pkg::OP_REMOVE, 0,  0, 1, 1,
                                     ale_pkg::ST_NOTFOUND, 0, 0, 0, 2));
    directed_plan.push_back(plan_row(ale_pkg::OP_POP,    0,  0, 1, 1,
                                     ale_pkg::ST_OK,      -1, 0, 0, 1));
    // fill to capacity with one repeated word, checked against the shadow list
    directed_plan.push_back(plan_row(ale_pkg::OP_APPEND, 0, 32'h7fff_ffff,
                                     ale_pkg::DEPTH - 1, 0, ale_pkg::ST_OK,
                                     0, 0, 0, 0));
    directed_plan.push_back(plan_row(ale_pkg::OP_APPEND, 0,  0, 1, 1,
                                     ale_pkg::ST_FULL, 0, 0, 0, ale_pkg::DEPTH));
    directed_plan.push_back(plan_row(ale_pkg::OP_INSERT, 16, 0, 1, 1,
                                     ale_pkg::ST_FULL, 0, 0, 0, ale_pkg::DEPTH));
    directed_plan.push_back(plan_row(ale_pkg::OP_READ,   15, 0, 1, 1,
                                     ale_pkg::ST_OK, 32'h7fff_ffff, 0, 0,
                                     ale_pkg::DEPTH));
    // every entry matches, so the whole list goes
    directed_plan.push_back(plan_row(ale_pkg::OP_REMOVE, 0, 32'h7fff_ffff, 1, 1,
                                     ale_pkg::ST_OK, 0, 0, ale_pkg::DEPTH, 0));

    shadow_fill = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[r])
      repeat (directed_plan[r].repeats)
        offer_command(directed_plan[r].cmd, directed_plan[r].typed, directed_plan[r].result);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      // back-pressure burst at the start of the random part
      if (phase == 0) hold_off_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer_command(random_command(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands with %0d results checked, list fill peaking at %0d.",
             commands_sent, results_seen, peak_fill);
    $display("Results by status: ok %0d, full %0d, empty %0d, range %0d, not found %0d.",
             status_tally[ale_pkg::ST_OK], status_tally[ale_pkg::ST_FULL],
             status_tally[ale_pkg::ST_EMPTY], status_tally[ale_pkg::ST_RANGE],
             status_tally[ale_pkg::ST_NOTFOUND]);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so that the
  // block fills up and drops in_tready while commands keep coming
  initial begin
    int hold_count;
    forever begin
      @(posedge clk);
      if (hold_off_request && !hold_off_done) begin
        out_tready <= 1'b0;
        for (hold_count = 1; hold_count < HOLD_OFF_CYCLES; hold_count++) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result transfer with no command outstanding: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (int'(want.status) < 5) status_tally[want.status]++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.data !== want.data) begin
          $error("data: expected %h, got %h", want.data, got.data);
          mismatch_count++;
        end
        if (got.found_at !== want.found_at) begin
          $error("found_at: expected %0d, got %0d", want.found_at, got.found_at);
          mismatch_count++;
        end
        if (got.removed !== want.removed) begin
          $error("removed: expected %0d, got %0d", want.removed, got.removed);
          mismatch_count++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
          mismatch_count++;
        end
        if (got.pad !== want.pad) begin
          $error("pad: expected %h, got %h", want.pad, got.pad);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop should the handshakes ever hang
  initial begin
    #(WATCHDOG_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ale_pkg.sv
rtl/ale_ram.sv
rtl/array_list_engine.sv
tb/testbench.sv
